[rtl/core/hpg_pkg.sv]
// shared widths, control structs and command codes for the permutation generator
// no dependencies; imported by the interfaces and every core module
package hpg_pkg;

  localparam int unsigned POS_W = 3;   // row position field
  localparam int unsigned SYM_W = 8;   // symbol field
  localparam int unsigned LVL_W = 3;   // one level counter
  localparam int unsigned LEN_W = 4;   // length register
  localparam int unsigned ARR_W = 64;  // packed arrangement
  localparam int unsigned CNT_W16 = 16; // permutation index

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // one read and one write of the row per cycle
  typedef struct packed {
    logic              load;    // row[addr_a] <= data
    logic              cap;     // tmp <= row[addr_a]
    logic              mv;      // row[addr_a] <= row[addr_b]
    logic              put;     // row[addr_b] <= tmp
    logic [POS_W-1:0]  addr_a;
    logic [POS_W-1:0]  addr_b;
    logic [SYM_W-1:0]  data;
  } row_cmd_t;

  typedef struct packed {
    logic clear_all;
    logic bump;
    logic zero;
  } lvl_cmd_t;

  typedef struct packed {
    logic             below;  // counter at the scanned level is below that level
    logic [LVL_W-1:0] cnt;
  } lvl_stat_t;

endpackage

[rtl/core/hpg_in_if.sv]
// input channel: load or step word with valid/ready
// depends on hpg_pkg
interface hpg_in_if import hpg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [POS_W-1:0] position;
  logic [SYM_W-1:0] symbol;

  modport source (output valid, cmd, position, symbol, input ready);
  modport sink   (input valid, cmd, position, symbol, output ready);
endinterface

[rtl/core/hpg_out_if.sv]
// result channel: arrangement, index and done flag with valid/ready
// depends on hpg_pkg
interface hpg_out_if import hpg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ARR_W-1:0]   arrangement;
  logic [CNT_W16-1:0] perm_index;
  logic               done_res;

  modport source (output valid, arrangement, perm_index, done_res, input ready);
  modport sink   (input valid, arrangement, perm_index, done_res, output ready);
endinterface

[rtl/core/hpg_cfg_if.sv]
// configuration write channel for the length register
// depends on hpg_pkg
interface hpg_cfg_if import hpg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[rtl/core/hpg_level_unit.sv]
// level counter bank with the shared compare and increment unit
// depends on hpg_pkg
module hpg_level_unit import hpg_pkg::*; #(
  parameter int unsigned MAX_LEN = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lvl_cmd_t                       cmd_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]   level_i,
  output lvl_stat_t                      stat_o
);

  localparam int unsigned IDX_W = $clog2(MAX_LEN);
  localparam int unsigned CNT_W = $clog2(MAX_LEN+1);

  logic [LVL_W-1:0] cnt_q [MAX_LEN];
  logic [IDX_W-1:0] idx;
  logic             idx_ok;
  logic [LVL_W-1:0] cur;

  assign idx    = level_i[IDX_W-1:0];
  assign idx_ok = level_i < CNT_W'(MAX_LEN);
  assign cur    = idx_ok ? cnt_q[idx] : '0;

  assign stat_o.cnt   = cur;
  assign stat_o.below = {1'b0, cur} < (LVL_W+1)'(level_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_LEN; k++) cnt_q[k] <= '0;
    end else if (cmd_i.clear_all) begin
      for (int k = 0; k < MAX_LEN; k++) cnt_q[k] <= '0;
    end else if (idx_ok && cmd_i.bump) begin
      cnt_q[idx] <= cur + LVL_W'(1);
    end else if (idx_ok && cmd_i.zero) begin
      cnt_q[idx] <= '0;
    end
  end

endmodule

[rtl/core/hpg_row_store.sv]
// symbol row with one read and one write port, swap holding register and packer
// depends on hpg_pkg
module hpg_row_store import hpg_pkg::*; #(
  parameter int unsigned MAX_LEN     = 8,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  row_cmd_t                      cmd_i,
  input  logic [$clog2(MAX_LEN+1)-1:0]  len_i,
  output logic [ARR_W-1:0]              arr_o
);

  localparam int unsigned IDX_W = $clog2(MAX_LEN);
  localparam int unsigned CNT_W = $clog2(MAX_LEN+1);
  localparam int unsigned SLOTS = ARR_W / 8;

  logic [SYMBOL_BITS-1:0] row_q [MAX_LEN];
  logic [SYMBOL_BITS-1:0] tmp_q;
  logic [SYMBOL_BITS-1:0] rd_data;
  logic [SYMBOL_BITS-1:0] wr_data;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       wr_addr;
  logic                   wr_en;

  assign rd_addr = cmd_i.mv ? cmd_i.addr_b[IDX_W-1:0] : cmd_i.addr_a[IDX_W-1:0];
  assign rd_data = row_q[rd_addr];
  assign wr_addr = cmd_i.put ? cmd_i.addr_b[IDX_W-1:0] : cmd_i.addr_a[IDX_W-1:0];
  assign wr_en   = cmd_i.load | cmd_i.mv | cmd_i.put;

  always_comb begin
    if (cmd_i.load) begin
      wr_data = cmd_i.data[SYMBOL_BITS-1:0];
    end else if (cmd_i.put) begin
      wr_data = tmp_q;
    end else begin
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_LEN; k++) row_q[k] <= '0;
    end else if (wr_en) begin
      row_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      tmp_q <= rd_data;
    end
  end

  // positions at or past the length read as zero
  for (genvar k = 0; k < SLOTS; k++) begin : g_pack
    if (k < MAX_LEN) begin : g_used
      assign arr_o[8*k +: 8] = (CNT_W'(k) < len_i) ? 8'(row_q[k]) : 8'h00;
    end else begin : g_unused
      assign arr_o[8*k +: 8] = 8'h00;
    end
  end

endmodule

[rtl/core/heap_permutation_generator_top.sv]
// heap permutation generator: a load word gives no result
// a step word goes straight to emit when it shows the loaded row or repeats a finished done,
// else it scans up from level 1 and swaps at the first level (1..n-1) whose counter is below it,
// or reports done when the scan runs past length n; levels go one per cycle through the
// shared counter compare unit, then swap states A, B, C and the emit state, which can stall
// on a full output register; reset (async, low) zeroes the row and counters, sets length to 1 and empties the output
module heap_permutation_generator_top import hpg_pkg::*; #(
  parameter int unsigned MAX_LEN     = 8,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hpg_in_if.sink     in_i,
  hpg_cfg_if.sink    cfg_i,
  hpg_out_if.source  out_o
);

  localparam int unsigned CNT_W = $clog2(MAX_LEN+1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_SWAP_A = 6'b000100,
    ST_SWAP_B = 6'b001000,
    ST_SWAP_C = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [LEN_W-1:0]   length_q, length_d;
  logic [CNT_W-1:0]   level_q, level_d;
  logic [CNT_W16-1:0] emitted_q, emitted_d;
  logic               finished_q, finished_d;
  logic               done_q, done_d;
  logic [POS_W-1:0]   swap_a_q, swap_a_d;
  logic [POS_W-1:0]   swap_b_q, swap_b_d;
  logic               out_valid_q, out_valid_d;
  logic [ARR_W-1:0]   out_arr_q;
  logic [CNT_W16-1:0] out_idx_q;
  logic               out_done_q;
  logic               out_load;

  logic [CNT_W-1:0]   n_eff;
  logic               in_fire;
  logic               pos_ok;
  row_cmd_t           row_cmd;
  lvl_cmd_t           lvl_cmd;
  lvl_stat_t          lvl_stat;
  logic [ARR_W-1:0]   arr;

  hpg_level_unit #(.MAX_LEN(MAX_LEN)) u_level (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (lvl_cmd),
    .level_i (level_q),
    .stat_o  (lvl_stat)
  );

  hpg_row_store #(.MAX_LEN(MAX_LEN), .SYMBOL_BITS(SYMBOL_BITS)) u_row (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (row_cmd),
    .len_i  (n_eff),
    .arr_o  (arr)
  );

  always_comb begin
    if (length_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (length_q > LEN_W'(MAX_LEN)) begin
      n_eff = CNT_W'(MAX_LEN);
    end else begin
      n_eff = CNT_W'(length_q);
    end
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign pos_ok      = {1'b0, in_i.position} < (POS_W+1)'(MAX_LEN);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid       = out_valid_q;
  assign out_o.arrangement = out_arr_q;
  assign out_o.perm_index  = out_idx_q;
  assign out_o.done_res    = out_done_q;

  always_comb begin
    state_d     = state_q;
    length_d    = length_q;
    level_d     = level_q;
    emitted_d   = emitted_q;
    finished_d  = finished_q;
    done_d      = done_q;
    swap_a_d    = swap_a_q;
    swap_b_d    = swap_b_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_load    = 1'b0;
    row_cmd     = '0;
    lvl_cmd     = '0;

    if (cfg_i.valid) begin
      length_d = cfg_i.data;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.cmd == CMD_LOAD) begin
            // positions past the row are dropped without a restart
            if (pos_ok) begin
              row_cmd.load      = 1'b1;
              row_cmd.addr_a    = in_i.position;
              row_cmd.data      = in_i.symbol;
              lvl_cmd.clear_all = 1'b1;
              emitted_d         = '0;
              finished_d        = 1'b0;
              level_d           = CNT_W'(1);
            end
          end else if (finished_q) begin
            done_d  = 1'b1;
            state_d = ST_EMIT;
          end else if (emitted_q == '0) begin
            // first step shows the row as loaded
            emitted_d = CNT_W16'(1);
            done_d    = 1'b0;
            state_d   = ST_EMIT;
          end else begin
            level_d = CNT_W'(1);
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (level_q >= n_eff) begin
          finished_d = 1'b1;
          done_d     = 1'b1;
          level_d    = CNT_W'(1);
          state_d    = ST_EMIT;
        end else if (lvl_stat.below) begin
          // odd level swaps at the counter, even level at position zero
          swap_a_d     = level_q[0] ? lvl_stat.cnt : '0;
          swap_b_d     = POS_W'(level_q);
          lvl_cmd.bump = 1'b1;
          emitted_d    = emitted_q + CNT_W16'(1);
          done_d       = 1'b0;
          level_d      = CNT_W'(1);
          state_d      = ST_SWAP_A;
        end else begin
          lvl_cmd.zero = 1'b1;
          level_d      = level_q + CNT_W'(1);
        end
      end
      ST_SWAP_A: begin
        row_cmd.cap    = 1'b1;
        row_cmd.addr_a = swap_a_q;
        state_d        = ST_SWAP_B;
      end
      ST_SWAP_B: begin
        row_cmd.mv     = 1'b1;
        row_cmd.addr_a = swap_a_q;
        row_cmd.addr_b = swap_b_q;
        state_d        = ST_SWAP_C;
      end
      ST_SWAP_C: begin
        row_cmd.put    = 1'b1;
        row_cmd.addr_b = swap_b_q;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        // wait for the output register to free up
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_load    = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      length_q    <= LEN_W'(1);
      level_q     <= CNT_W'(1);
      emitted_q   <= '0;
      finished_q  <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      length_q    <= length_d;
      level_q     <= level_d;
      emitted_q   <= emitted_d;
      finished_q  <= finished_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    swap_a_q <= swap_a_d;
    swap_b_q <= swap_b_d;
    if (out_load) begin
      out_arr_q  <= arr;
      out_idx_q  <= emitted_q;
      out_done_q <= done_q;
    end
  end

endmodule

[test/tb_heap_permutation_generator_top.sv]
`timescale 1ns / 100ps
// testbench for heap_permutation_generator_top: load and step words go in, a local heap
// model predicts every permutation word, results are checked in order of arrival
// depends on hpg_pkg and the hpg_in_if, hpg_cfg_if and hpg_out_if interfaces
module tb_heap_permutation_generator_top;
  import hpg_pkg::*;

  typedef struct packed {
    logic [ARR_W-1:0]   arrangement;
    logic [CNT_W16-1:0] perm_index;
    logic               done_res;
  } perm_res_t;

  localparam int TAIL_CYCLES = 16;  // covers the longest step

  logic clk = 1'b0;
  logic rst_n;

  hpg_in_if  in_if ();
  hpg_cfg_if cfg_if ();
  hpg_out_if out_if ();

  heap_permutation_generator_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // local copy of the generator state
  logic [SYM_W-1:0]   row_m [8];
  logic [LVL_W-1:0]   lvl_cnt_m [8];
  logic [3:0]         scan_m;
  logic [CNT_W16-1:0] emitted_m;
  logic               finished_m;
  logic [LEN_W-1:0]   length_m;

  perm_res_t pending_perms [$];

  int err_cnt       = 0;
  int items_sent    = 0;
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_len      = 0;
  bit holding       = 1'b0;
  event hold_go;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver side: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    out_if.ready <= holding ? 1'b0 : ($urandom_range(99) >= snk_stall_pct);
  end

  initial begin
    forever begin
      @(hold_go);
      holding = 1'b1;
      repeat (hold_len) @(posedge clk);
      holding = 1'b0;
    end
  end

  always @(posedge clk) begin : check_result
    perm_res_t exp_r;
    if (out_if.valid && out_if.ready) begin
      if (pending_perms.size() == 0) begin
        err_cnt++;
        $display("%0t unexpected result: arrangement %h index %0d done %b", $time,
                 out_if.arrangement, out_if.perm_index, out_if.done_res);
      end else begin
        exp_r = pending_perms.pop_front();
        if (out_if.arrangement !== exp_r.arrangement) begin
          err_cnt++;
          $display("%0t arrangement mismatch: expected %h actual %h", $time,
                   exp_r.arrangement, out_if.arrangement);
        end
        if (out_if.perm_index !== exp_r.perm_index) begin
          err_cnt++;
          $display("%0t perm_index mismatch: expected %0d actual %0d", $time,
                   exp_r.perm_index, out_if.perm_index);
        end
        if (out_if.done_res !== exp_r.done_res) begin
          err_cnt++;
          $display("%0t done_res mismatch: expected %b actual %b", $time,
                   exp_r.done_res, out_if.done_res);
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("heap_permutation_generator_top regression: fail");
    $finish;
  end

  function automatic int eff_length(input logic [LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > 8) return 8;
    return len;
  endfunction

  task automatic restart_heap();
    for (int k = 0; k < 8; k++) lvl_cnt_m[k] = '0;
    scan_m     = 4'd1;
    emitted_m  = '0;
    finished_m = 1'b0;
  endtask

  // applies one accepted word to the local state, queues the permutation word it yields
  task automatic advance_heap(input logic cmd, input logic [POS_W-1:0] pos,
                              input logic [SYM_W-1:0] sym);
    int n;
    int i;
    bit hit;
    bit done;
    logic [LVL_W-1:0] c;
    logic [SYM_W-1:0] t;
    perm_res_t r;
    n = eff_length(length_m);
    if (cmd == CMD_LOAD) begin
      row_m[pos] = sym;
      restart_heap();
      return;
    end
    done = 1'b0;
    if (finished_m) begin
      done = 1'b1;
    end else if (emitted_m == 0) begin
      emitted_m = 1;
    end else begin
      i = (scan_m < 1) ? 1 : scan_m;
      hit = 1'b0;
      while (!hit && i < n) begin
        c = lvl_cnt_m[i];
        if (c < i) begin
          // even level swaps with position 0, odd level with the counter's position
          if (i % 2 == 0) begin
            t = row_m[0];
            row_m[0] = row_m[i];
            row_m[i] = t;
          end else begin
            t = row_m[c];
            row_m[c] = row_m[i];
            row_m[i] = t;
          end
          lvl_cnt_m[i] = c + 1'b1;
          scan_m = 4'd1;
          emitted_m = emitted_m + 1'b1;
          hit = 1'b1;
        end else begin
          lvl_cnt_m[i] = '0;
          i++;
        end
      end
      if (!hit) begin
        finished_m = 1'b1;
        scan_m = 4'd1;
        done = 1'b1;
      end
    end
    r.arrangement = '0;
    for (int k = 0; k < n; k++) r.arrangement[8*k +: 8] = row_m[k];
    r.perm_index = emitted_m;
    r.done_res = done;
    pending_perms.push_back(r);
  endtask

  // entered and left at a falling edge; valid stays high for a following word
  task automatic send_word(input logic cmd, input logic [POS_W-1:0] pos,
                           input logic [SYM_W-1:0] sym);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.cmd      <= cmd;
    in_if.position <= pos;
    in_if.symbol   <= sym;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    advance_heap(cmd, pos, sym);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_load(input logic [POS_W-1:0] pos, input logic [SYM_W-1:0] sym);
    send_word(CMD_LOAD, pos, sym);
  endtask

  task automatic run_steps(input int cnt);
    repeat (cnt) send_word(CMD_STEP, POS_W'($urandom_range(7)), SYM_W'($urandom_range(255)));
  endtask

  task automatic send_random_load();
    send_load(POS_W'($urandom_range(7)), SYM_W'($urandom_range(255)));
  endtask

  // input quiet, every result in, then room for a load still in flight
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_perms.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= len;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    length_m = len;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_idle(input int src_pct, input int snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  task automatic test_directed_rows();
    set_idle(0, 0);
    // length one straight after reset: zero row, then done
    run_steps(2);
    write_length(3);
    send_load(0, 8'hFF);
    send_load(1, 8'h00);
    send_load(2, 8'h5A);
    send_load(7, 8'hA5);
    // six permutations, done, then a step after the end
    run_steps(8);
    send_load(1, 8'h3C);
    run_steps(2);
    // length 0 acts as one and ends the run in progress
    write_length(0);
    run_steps(3);
    // length above the row size acts as the full row
    write_length(15);
    send_load(4, 8'h81);
    run_steps(6);
  endtask

  task automatic test_length_change();
    set_idle(0, 0);
    write_length(4);
    for (int k = 0; k < 4; k++) send_load(POS_W'(k), SYM_W'($urandom_range(255)));
    run_steps(10);
    // counters carry over into the new length
    write_length(6);
    run_steps(30);
    write_length(2);
    run_steps(4);
    write_length(8);
    run_steps(5);
    send_random_load();
    run_steps(60);
  endtask

  task automatic test_full_six();
    set_idle(27, 27);
    write_length(6);
    for (int k = 0; k < 6; k++) send_load(POS_W'(k), SYM_W'($urandom_range(255)));
    run_steps(722);
  endtask

  task automatic test_backpressure();
    set_idle(0, 0);
    write_length(5);
    for (int k = 0; k < 5; k++) send_load(POS_W'(k), SYM_W'($urandom_range(255)));
    hold_len = 300;
    ->hold_go;
    for (int k = 0; k < 80; k++) begin
      if (k % 20 == 19) send_random_load();
      run_steps(1);
    end
    wait_idle();
  endtask

  // one well-formed run: length, a full row of loads, then steps, with a little noise
  task automatic random_sequence();
    int pick;
    int len;
    int n;
    int steps;
    int j;
    int tmp;
    int order [8];
    pick = $urandom_range(99);
    if (pick < 6) len = $urandom_range(1) ? 0 : $urandom_range(9, 15);
    else if (pick < 10) len = $urandom_range(6, 8);
    else len = $urandom_range(1, 5);
    if ($urandom_range(99) < 90) write_length(LEN_W'(len));
    n = eff_length(length_m);
    for (int k = 0; k < 8; k++) order[k] = k;
    for (int k = 7; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < n; k++) send_load(POS_W'(order[k]), SYM_W'($urandom_range(255)));
    repeat ($urandom_range(2)) send_random_load();
    if (n <= 5) begin
      steps = 1;
      for (int k = 2; k <= n; k++) steps *= k;
      steps += 1 + $urandom_range(3);
    end else begin
      steps = $urandom_range(20, 120);
    end
    for (int k = 0; k < steps; k++) begin
      // occasional load restarts the run in progress
      if ($urandom_range(99) < 2) send_random_load();
      run_steps(1);
    end
  endtask

  task automatic test_random_sequences();
    int start;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_idle(0, 0);
        1: set_idle(51, 0);
        2: set_idle(0, 51);
        default: set_idle(27, 27);
      endcase
      start = items_sent;
      while (items_sent - start < 130) random_sequence();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.cmd      = CMD_LOAD;
    in_if.position = '0;
    in_if.symbol   = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    out_if.ready   = 1'b0;
    for (int k = 0; k < 8; k++) row_m[k] = '0;
    restart_heap();
    length_m = 4'd1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed_rows();
    test_length_change();
    test_full_six();
    test_backpressure();
    test_random_sequences();

    wait_idle();
    if (err_cnt == 0) begin
      $display("heap_permutation_generator_top regression: pass");
    end else begin
      $display("heap_permutation_generator_top regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/hpg_pkg.sv
rtl/core/hpg_in_if.sv
rtl/core/hpg_out_if.sv
rtl/core/hpg_cfg_if.sv
rtl/core/hpg_level_unit.sv
rtl/core/hpg_row_store.sv
rtl/core/heap_permutation_generator_top.sv
test/tb_heap_permutation_generator_top.sv
